### sv/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg: shared types and constants for the box collide-and-slide unit
// Field widths, command and register codes, sequencer states and the
// control word that travels down the chain of box cells.
// ----------------------------------------------------------------------------
`default_nettype none

package acs_pkg;

    localparam int NUM_BOXES_DEF   = 8;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int EXT_W   = 15;   // box size, unsigned Q7.8
    localparam int RAD_W   = 15;   // player radius, unsigned Q7.8
    localparam int WALLS_W = 4;
    localparam int SLOT_W  = 3;
    localparam int AXIS_W  = 2;
    localparam int CFG_W   = 15;   // widest register
    localparam int CFG_IDX_W = 1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WALLS  = 1'b1;

    localparam int NUM_AXES = 3;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // which point test is travelling down the chain
    typedef enum logic [1:0] {
        PH_NEW,
        PH_X,
        PH_Z,
        PH_Y
    } phase_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } chain_ctl_t;

    typedef struct packed {
        logic              en;
        logic [AXIS_W-1:0] axis;
    } box_wr_t;

endpackage

`default_nettype wire

### sv/acs_cell.sv
// ----------------------------------------------------------------------------
// acs_cell: one box of the collision table
// Holds the center and size of one box on each axis, tests the point that
// arrives from the previous cell against the box grown by the radius, and
// hands the point and the running hit flag to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_cell
    import acs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire box_wr_t                       wr,
    input  wire logic signed [COORD_WIDTH-1:0] wr_center,
    input  wire logic        [EXT_W-1:0]       wr_extent,
    input  wire logic        [RAD_W-1:0]       radius,
    input  wire logic                          active,
    input  wire chain_ctl_t                    in_ctl,
    input  wire logic signed [COORD_WIDTH-1:0] in_x,
    input  wire logic signed [COORD_WIDTH-1:0] in_y,
    input  wire logic signed [COORD_WIDTH-1:0] in_z,
    output chain_ctl_t                         out_ctl,
    output logic signed [COORD_WIDTH-1:0]      out_x,
    output logic signed [COORD_WIDTH-1:0]      out_y,
    output logic signed [COORD_WIDTH-1:0]      out_z
);

    localparam int CMP_W = (COORD_WIDTH + 2 > EXT_W + 2) ? COORD_WIDTH + 2 : EXT_W + 2;

    logic signed [COORD_WIDTH-1:0] center_reg [NUM_AXES];
    logic        [EXT_W-1:0]       size_reg   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] pt         [NUM_AXES];
    logic        [NUM_AXES-1:0]    axis_in;
    logic                          in_box;
    logic [CMP_W-1:0]              lim;
    logic [CMP_W-1:0]              dbl_mag;
    logic [COORD_WIDTH:0]          diff;
    logic [COORD_WIDTH:0]          mag;

    chain_ctl_t                    ctl_reg;
    chain_ctl_t                    ctl_next;
    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] y_reg;
    logic signed [COORD_WIDTH-1:0] z_reg;

    assign pt[0] = in_x;
    assign pt[1] = in_y;
    assign pt[2] = in_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                center_reg[a] <= '0;
                size_reg[a]   <= '0;
            end
        end
        else
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (wr.en && wr.axis == AXIS_W'(a))
                begin
                    center_reg[a] <= wr_center;
                    size_reg[a]   <= wr_extent;
                end
            end
        end
    end

    // |2*(p-c)| <= size + 2*radius on every axis
    always_comb
    begin
        axis_in = '0;
        lim     = '0;
        dbl_mag = '0;
        diff    = '0;
        mag     = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            diff = {pt[a][COORD_WIDTH-1], pt[a]}
                 - {center_reg[a][COORD_WIDTH-1], center_reg[a]};
            mag  = diff[COORD_WIDTH] ? (~diff + 1'b1) : diff;
            dbl_mag = CMP_W'({mag, 1'b0});
            lim  = CMP_W'(size_reg[a]) + CMP_W'({radius, 1'b0});
            axis_in[a] = (dbl_mag <= lim);
        end
        in_box = &axis_in;
    end

    always_comb
    begin
        ctl_next.valid = in_ctl.valid;
        ctl_next.hit   = in_ctl.hit | (active & in_box);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= in_x;
        y_reg <= in_y;
        z_reg <= in_z;
    end

    assign out_ctl = ctl_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_z   = z_reg;

endmodule

`default_nettype wire

### sv/aabb_collide_and_slide_unit.sv
// ----------------------------------------------------------------------------
// aabb_collide_and_slide_unit: point-versus-box collision with axis slide
// A load transaction writes one axis of one box and finishes in its own
// cycle, with no result. A resolve transaction sends test points down a
// chain of NUM_BOXES box cells, one cell per cycle. A clear move needs one
// test and done pulses once it leaves the last cell; a blocked move needs
// four tests (new point, then X, Z and Y trials), each sent as the one before
// leaves the last cell, and done pulses once the Y trial leaves it.
// busy is high from the cycle after a resolve is taken until done pulses.
// done pulses for exactly one cycle and cannot be held off; the result stays.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_collide_and_slide_unit
    import acs_pkg::*;
#(
    parameter int NUM_BOXES   = NUM_BOXES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [CFG_W-1:0]       cfg_wdata,

    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cmd,
    input  wire logic        [SLOT_W-1:0]      box_slot,
    input  wire logic        [AXIS_W-1:0]      box_axis,
    input  wire logic signed [COORD_WIDTH-1:0] box_center,
    input  wire logic        [EXT_W-1:0]       box_extent,
    input  wire logic signed [COORD_WIDTH-1:0] old_x,
    input  wire logic signed [COORD_WIDTH-1:0] old_y,
    input  wire logic signed [COORD_WIDTH-1:0] old_z,
    input  wire logic signed [COORD_WIDTH-1:0] new_x,
    input  wire logic signed [COORD_WIDTH-1:0] new_y,
    input  wire logic signed [COORD_WIDTH-1:0] new_z,

    output logic                               done,
    output logic signed [COORD_WIDTH-1:0]      resolved_x,
    output logic signed [COORD_WIDTH-1:0]      resolved_y,
    output logic signed [COORD_WIDTH-1:0]      resolved_z,
    output logic                               hit
);

    logic [RAD_W-1:0]   radius_reg;
    logic [WALLS_W-1:0] walls_reg;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic signed [COORD_WIDTH-1:0] old_x_reg, old_y_reg, old_z_reg;
    logic signed [COORD_WIDTH-1:0] new_x_reg, new_y_reg, new_z_reg;
    logic signed [COORD_WIDTH-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic signed [COORD_WIDTH-1:0] res_x_next, res_y_next, res_z_next;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [COORD_WIDTH-1:0] out_x_next, out_y_next, out_z_next;
    logic                          hit_reg, hit_next;
    logic                          done_reg, done_next;

    logic                          accept;
    logic                          inject;
    logic signed [COORD_WIDTH-1:0] inj_x, inj_y, inj_z;
    logic signed [COORD_WIDTH-1:0] rx, ry, rz;

    chain_ctl_t                    chain_ctl [NUM_BOXES+1];
    logic signed [COORD_WIDTH-1:0] chain_x   [NUM_BOXES+1];
    logic signed [COORD_WIDTH-1:0] chain_y   [NUM_BOXES+1];
    logic signed [COORD_WIDTH-1:0] chain_z   [NUM_BOXES+1];
    chain_ctl_t                    tail;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign tail   = chain_ctl[NUM_BOXES];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            walls_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_wdata[RAD_W-1:0];
                REG_WALLS:  walls_reg  <= cfg_wdata[WALLS_W-1:0];
                default:    ;
            endcase
        end
    end

    // chain of box cells
    assign chain_ctl[0].valid = inject;
    assign chain_ctl[0].hit   = 1'b0;
    assign chain_x[0]         = inj_x;
    assign chain_y[0]         = inj_y;
    assign chain_z[0]         = inj_z;

    for (genvar i = 0; i < NUM_BOXES; i++)
    begin : g_cell
        box_wr_t wr;
        logic    active;

        assign wr.en   = accept && (cmd == CMD_LOAD) && (int'(box_slot) == i)
                       && (int'(box_axis) < NUM_AXES);
        assign wr.axis = box_axis;
        assign active  = (int'(walls_reg) > i);

        acs_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .wr_center (box_center),
            .wr_extent (box_extent),
            .radius    (radius_reg),
            .active    (active),
            .in_ctl    (chain_ctl[i]),
            .in_x      (chain_x[i]),
            .in_y      (chain_y[i]),
            .in_z      (chain_z[i]),
            .out_ctl   (chain_ctl[i+1]),
            .out_x     (chain_x[i+1]),
            .out_y     (chain_y[i+1]),
            .out_z     (chain_z[i+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_RESOLVE)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tail.valid && ((phase_reg == PH_NEW && !tail.hit) || phase_reg == PH_Y))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: which point goes into the chain, slide bookkeeping
    always_comb
    begin
        rx         = res_x_reg;
        ry         = res_y_reg;
        rz         = res_z_reg;
        inject     = 1'b0;
        inj_x      = new_x;
        inj_y      = new_y;
        inj_z      = new_z;
        phase_next = phase_reg;
        res_x_next = res_x_reg;
        res_y_next = res_y_reg;
        res_z_next = res_z_reg;
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        out_z_next = out_z_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_RESOLVE)
                begin
                    inject     = 1'b1;
                    phase_next = PH_NEW;
                end
            end
            ST_RUN:
            begin
                if (tail.valid)
                begin
                    case (phase_reg)
                        PH_NEW:
                        begin
                            if (!tail.hit)
                            begin
                                done_next  = 1'b1;
                                out_x_next = new_x_reg;
                                out_y_next = new_y_reg;
                                out_z_next = new_z_reg;
                                hit_next   = 1'b0;
                            end
                            else
                            begin
                                res_x_next = old_x_reg;
                                res_y_next = old_y_reg;
                                res_z_next = old_z_reg;
                                inject     = 1'b1;
                                inj_x      = new_x_reg;
                                inj_y      = old_y_reg;
                                inj_z      = old_z_reg;
                                phase_next = PH_X;
                            end
                        end
                        PH_X:
                        begin
                            rx         = tail.hit ? res_x_reg : new_x_reg;
                            res_x_next = rx;
                            inject     = 1'b1;
                            inj_x      = rx;
                            inj_y      = old_y_reg;
                            inj_z      = new_z_reg;
                            phase_next = PH_Z;
                        end
                        PH_Z:
                        begin
                            rz         = tail.hit ? res_z_reg : new_z_reg;
                            res_z_next = rz;
                            inject     = 1'b1;
                            inj_x      = res_x_reg;
                            inj_y      = new_y_reg;
                            inj_z      = rz;
                            phase_next = PH_Y;
                        end
                        PH_Y:
                        begin
                            ry         = tail.hit ? res_y_reg : new_y_reg;
                            res_y_next = ry;
                            done_next  = 1'b1;
                            out_x_next = res_x_reg;
                            out_y_next = ry;
                            out_z_next = res_z_reg;
                            hit_next   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NEW;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_RESOLVE)
        begin
            old_x_reg <= old_x;
            old_y_reg <= old_y;
            old_z_reg <= old_z;
            new_x_reg <= new_x;
            new_y_reg <= new_y;
            new_z_reg <= new_z;
        end
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        res_z_reg <= res_z_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_z_reg <= out_z_next;
        hit_reg   <= hit_next;
    end

    assign done       = done_reg;
    assign resolved_x = out_x_reg;
    assign resolved_y = out_y_reg;
    assign resolved_z = out_z_reg;
    assign hit        = hit_reg;

endmodule

`default_nettype wire

### verif/acs_slide_checker.sv
// ----------------------------------------------------------------------------
// acs_slide_checker: result checker for the box collide-and-slide unit
// Mirrors the box table and both registers from the transactions it sees,
// predicts each resolved move when start is taken, and compares every done
// strobe against the oldest prediction. Exposes error, pending, checked and blocked counts.
// ----------------------------------------------------------------------------
module acs_slide_checker
    import acs_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic        [CFG_IDX_W-1:0]         cfg_index,
    input  logic        [CFG_W-1:0]             cfg_wdata,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                cmd,
    input  logic        [SLOT_W-1:0]            box_slot,
    input  logic        [AXIS_W-1:0]            box_axis,
    input  logic signed [COORD_WIDTH_DEF-1:0]   box_center,
    input  logic        [EXT_W-1:0]             box_extent,
    input  logic signed [COORD_WIDTH_DEF-1:0]   old_x,
    input  logic signed [COORD_WIDTH_DEF-1:0]   old_y,
    input  logic signed [COORD_WIDTH_DEF-1:0]   old_z,
    input  logic signed [COORD_WIDTH_DEF-1:0]   new_x,
    input  logic signed [COORD_WIDTH_DEF-1:0]   new_y,
    input  logic signed [COORD_WIDTH_DEF-1:0]   new_z,
    input  logic                                done,
    input  logic signed [COORD_WIDTH_DEF-1:0]   resolved_x,
    input  logic signed [COORD_WIDTH_DEF-1:0]   resolved_y,
    input  logic signed [COORD_WIDTH_DEF-1:0]   resolved_z,
    input  logic                                hit,
    output int                                  errors,
    output int                                  pending,
    output int                                  moves_checked,
    output int                                  moves_blocked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = NUM_BOXES_DEF * NUM_AXES;

    typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   hit;
    } move_t;

    coord_t           box_ctr  [TABLE_SIZE];
    logic [EXT_W-1:0] box_size [TABLE_SIZE];
    logic [RAD_W-1:0] radius;
    logic [WALLS_W-1:0] walls;

    move_t expected_moves [$];
    move_t want;
    int    err_cnt;
    int    checked_cnt;
    int    blocked_cnt;
    int    k;

    // inclusive test against every active box grown by the radius
    function automatic logic point_blocked(input coord_t px, input coord_t py,
                                           input coord_t pz);
        int   n;
        int   b;
        int   a;
        int   p [NUM_AXES];
        int   delta;
        int   lim;
        logic in_box;
        logic blocked;
        n = (walls > NUM_BOXES_DEF) ? NUM_BOXES_DEF : int'(walls);
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        blocked = 1'b0;
        for (b = 0; b < n; b++)
        begin
            in_box = 1'b1;
            for (a = 0; a < NUM_AXES; a++)
            begin
                delta = 2 * (p[a] - int'(box_ctr[b * NUM_AXES + a]));
                if (delta < 0)
                    delta = -delta;
                lim = int'(box_size[b * NUM_AXES + a]) + 2 * int'(radius);
                if (delta > lim)
                    in_box = 1'b0;
            end
            if (in_box)
                blocked = 1'b1;
        end
        return blocked;
    endfunction

    // slide order on a blocked move: X, then Z, then Y
    function automatic move_t predict_move(input coord_t ox, input coord_t oy,
                                           input coord_t oz, input coord_t nx,
                                           input coord_t ny, input coord_t nz);
        move_t r;
        if (!point_blocked(nx, ny, nz))
        begin
            r.x   = nx;
            r.y   = ny;
            r.z   = nz;
            r.hit = 1'b0;
        end
        else
        begin
            r.x   = ox;
            r.y   = oy;
            r.z   = oz;
            r.hit = 1'b1;
            if (!point_blocked(nx, oy, oz))
                r.x = nx;
            if (!point_blocked(r.x, oy, nz))
                r.z = nz;
            if (!point_blocked(r.x, ny, r.z))
                r.y = ny;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < TABLE_SIZE; k++)
            begin
                box_ctr[k]  = '0;
                box_size[k] = '0;
            end
            radius = '0;
            walls  = '0;
            expected_moves.delete();
            err_cnt     = 0;
            checked_cnt = 0;
            blocked_cnt = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_moves.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d hit=%0b",
                             $time, resolved_x, resolved_y, resolved_z, hit);
                end
                else
                begin
                    want = expected_moves.pop_front();
                    checked_cnt++;
                    if (want.hit)
                        blocked_cnt++;
                    if (resolved_x !== want.x || resolved_y !== want.y ||
                        resolved_z !== want.z || hit !== want.hit)
                    begin
                        err_cnt++;
                        $display("%0t: move mismatch: expected x=%0d y=%0d z=%0d hit=%0b",
                                 $time, want.x, want.y, want.z, want.hit);
                        $display("%0t:                  actual x=%0d y=%0d z=%0d hit=%0b",
                                 $time, resolved_x, resolved_y, resolved_z, hit);
                    end
                end
            end

            if (start && !busy)
            begin
                if (cmd == CMD_LOAD)
                begin
                    // axis 3 loads are dropped
                    if (box_axis < NUM_AXES && box_slot < NUM_BOXES_DEF)
                    begin
                        box_ctr[box_slot * NUM_AXES + box_axis]  = box_center;
                        box_size[box_slot * NUM_AXES + box_axis] = box_extent;
                    end
                end
                else
                begin
                    expected_moves = {expected_moves,
                                      predict_move(old_x, old_y, old_z,
                                                   new_x, new_y, new_z)};
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIUS: radius = cfg_wdata[RAD_W-1:0];
                    REG_WALLS:  walls  = cfg_wdata[WALLS_W-1:0];
                    default: ;
                endcase
            end
        end

        errors        <= err_cnt;
        pending       <= expected_moves.size();
        moves_checked <= checked_cnt;
        moves_blocked <= blocked_cnt;
    end

endmodule

### verif/tb_aabb_collide_and_slide_unit.sv
// ----------------------------------------------------------------------------
// tb_aabb_collide_and_slide_unit: regression for the collide-and-slide unit
// Directed box loads and moves on the edges of the table and the registers,
// then randomized phases with fresh boxes, radius and wall count, mixing
// well-formed moves near the boxes with full-range noise and sender gaps.
// ----------------------------------------------------------------------------
module tb_aabb_collide_and_slide_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import acs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LATENCY_WAIT = 4 * NUM_BOXES_DEF + 8;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 120;

    typedef struct packed {
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [AXIS_W-1:0]  axis;
        logic [15:0]        center;
        logic [EXT_W-1:0]   extent;
        logic [15:0]        ox;
        logic [15:0]        oy;
        logic [15:0]        oz;
        logic [15:0]        nx;
        logic [15:0]        ny;
        logic [15:0]        nz;
    } xact_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  start = 1'b0;
    logic                  cmd = CMD_LOAD;
    logic [SLOT_W-1:0]     box_slot = '0;
    logic [AXIS_W-1:0]     box_axis = '0;
    logic signed [15:0]    box_center = '0;
    logic [EXT_W-1:0]      box_extent = '0;
    logic signed [15:0]    old_x = '0;
    logic signed [15:0]    old_y = '0;
    logic signed [15:0]    old_z = '0;
    logic signed [15:0]    new_x = '0;
    logic signed [15:0]    new_y = '0;
    logic signed [15:0]    new_z = '0;
    logic                  busy;
    logic                  done;
    logic signed [15:0]    resolved_x;
    logic signed [15:0]    resolved_y;
    logic signed [15:0]    resolved_z;
    logic                  hit;

    int errors;
    int pending;
    int moves_checked;
    int moves_blocked;
    int cycle_count = 0;
    int items_sent = 0;
    int gap_pct = 0;
    int phases_run = 0;

    aabb_collide_and_slide_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .box_slot   (box_slot),
        .box_axis   (box_axis),
        .box_center (box_center),
        .box_extent (box_extent),
        .old_x      (old_x),
        .old_y      (old_y),
        .old_z      (old_z),
        .new_x      (new_x),
        .new_y      (new_y),
        .new_z      (new_z),
        .done       (done),
        .resolved_x (resolved_x),
        .resolved_y (resolved_y),
        .resolved_z (resolved_z),
        .hit        (hit)
    );

    acs_slide_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .box_slot      (box_slot),
        .box_axis      (box_axis),
        .box_center    (box_center),
        .box_extent    (box_extent),
        .old_x         (old_x),
        .old_y         (old_y),
        .old_z         (old_z),
        .new_x         (new_x),
        .new_y         (new_y),
        .new_z         (new_z),
        .done          (done),
        .resolved_x    (resolved_x),
        .resolved_y    (resolved_y),
        .resolved_z    (resolved_z),
        .hit           (hit),
        .errors        (errors),
        .pending       (pending),
        .moves_checked (moves_checked),
        .moves_blocked (moves_blocked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("aabb_collide_and_slide_unit regression: fail");
            $finish;
        end
    end

    // random offset around base, clamped to the coordinate range
    function automatic int near(input int base, input int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // coordinate fields of a load are don't-care, so fill them with noise
    function automatic xact_t mk_load(input int slot, input int axis,
                                      input int center, input int extent);
        xact_t t;
        t        = '0;
        t.op     = CMD_LOAD;
        t.slot   = slot[SLOT_W-1:0];
        t.axis   = axis[AXIS_W-1:0];
        t.center = center[15:0];
        t.extent = extent[EXT_W-1:0];
        t.ox     = 16'($urandom);
        t.oy     = 16'($urandom);
        t.oz     = 16'($urandom);
        t.nx     = 16'($urandom);
        t.ny     = 16'($urandom);
        t.nz     = 16'($urandom);
        return t;
    endfunction

    function automatic xact_t mk_move(input int ox, input int oy, input int oz,
                                      input int nx, input int ny, input int nz);
        xact_t t;
        t        = '0;
        t.op     = CMD_RESOLVE;
        t.slot   = SLOT_W'($urandom);
        t.axis   = AXIS_W'($urandom);
        t.center = 16'($urandom);
        t.extent = EXT_W'($urandom);
        t.ox     = ox[15:0];
        t.oy     = oy[15:0];
        t.oz     = oz[15:0];
        t.nx     = nx[15:0];
        t.ny     = ny[15:0];
        t.nz     = nz[15:0];
        return t;
    endfunction

    // present one transaction and hold it until start is taken
    task automatic send(input xact_t t);
        start      <= 1'b1;
        cmd        <= t.op;
        box_slot   <= t.slot;
        box_axis   <= t.axis;
        box_center <= t.center;
        box_extent <= t.extent;
        old_x      <= t.ox;
        old_y      <= t.oy;
        old_z      <= t.oz;
        new_x      <= t.nx;
        new_y      <= t.ny;
        new_z      <= t.nz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    // stop issuing and wait for every outstanding move to come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic directed();
        // no walls active after reset: everything passes
        send(mk_move(0, 0, 0, 32767, -32768, 32767));
        send(mk_move(0, 0, 0, -32768, 32767, -32768));
        // box 0: cube of size 512 at the origin
        send(mk_load(0, 0, 0, 512));
        send(mk_load(0, 1, 0, 512));
        send(mk_load(0, 2, 0, 512));
        // box 7 at the corners of the coordinate range
        send(mk_load(7, 0, 32767, 32767));
        send(mk_load(7, 1, -32768, 0));
        send(mk_load(7, 2, 32767, 32767));
        // axis 3 load must not touch box 0
        send(mk_load(0, 3, 12345, 1));
        send(mk_move(-1024, 0, 0, 0, 0, 0));
        drain();
        write_reg(REG_WALLS, CFG_W'(1));

        send(mk_move(-1024, 0, 0, 0, 0, 0));
        // exactly on the face is still a hit, one step out is clear
        send(mk_move(512, 0, 0, 256, 0, 0));
        send(mk_move(512, 0, 0, 257, 0, 0));
        send(mk_move(-512, 0, 100, 0, 0, 150));
        drain();
        write_reg(REG_RADIUS, CFG_W'(128));
        // wall count above the table size; unloaded boxes sit at the origin
        write_reg(REG_WALLS, CFG_W'(15));

        send(mk_move(1000, 0, 0, 384, 0, 0));
        send(mk_move(0, 0, 0, 32767, -32768, 32767));
        send(mk_move(-600, 700, -600, 100, 100, 100));
        drain();
        write_reg(REG_RADIUS, CFG_W'(32767));
        write_reg(REG_WALLS, CFG_W'(8));

        send(mk_move(-32768, -32768, -32768, 32767, 32767, 32767));
        send(mk_move(0, 0, 0, -32768, 32767, -32768));
        drain();
    endtask

    task automatic run_phase(input int p, input int count);
        int         span;
        int         step;
        int         r;
        int         k;
        int         ox;
        int         oy;
        int         oz;
        int         rad;
        logic [3:0] walls_v;
        xact_t      t;

        case (p % 4)
            0:       rad = $urandom_range(0, 256);
            1:       rad = 0;
            2:       rad = $urandom_range(0, 32767);
            default: rad = (p == 3) ? 32767 : $urandom_range(0, 512);
        endcase
        if (p == 0)
            walls_v = 4'd8;
        else if (p == 1)
            walls_v = 4'd15;
        else if (p == 5)
            walls_v = 4'd0;
        else
            walls_v = 4'($urandom_range(1, 15));

        drain();
        write_reg(REG_RADIUS, CFG_W'(rad));
        // upper data bits are outside the register and must be dropped
        write_reg(REG_WALLS, {11'($urandom_range(0, 2047)), walls_v});

        case (p % 4)
            0:       gap_pct = 0;
            1:       gap_pct = 52;
            2:       gap_pct = 0;
            default: gap_pct = 23;
        endcase
        span = $urandom_range(256, 4096);
        step = span / 4 + 1;

        for (k = 0; k < NUM_BOXES_DEF * NUM_AXES; k++)
            send(mk_load(k / NUM_AXES, k % NUM_AXES, near(0, span),
                         $urandom_range(0, span / 2)));

        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 12)
                t = mk_load($urandom_range(0, 7), $urandom_range(0, 3),
                            near(0, span), $urandom_range(0, span / 2));
            else if (r < 16)
                t = mk_load($urandom_range(0, 7), $urandom_range(0, 3),
                            int'($signed(16'($urandom))), $urandom_range(0, 32767));
            else if (r < 26)
                t = mk_move(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                            int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                            int'($signed(16'($urandom))), int'($signed(16'($urandom))));
            else
            begin
                ox = near(0, span);
                oy = near(0, span);
                oz = near(0, span);
                t = mk_move(ox, oy, oz,
                            near(ox, step),
                            ($urandom_range(3) == 0) ? oy : near(oy, step),
                            near(oz, step));
            end
            // now and then hold off until the unit is empty
            if ($urandom_range(49) == 0)
                drain();
            send(t);
        end
        phases_run++;
    endtask

    initial
    begin
        int p;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        for (p = 0; p < NUM_PHASES; p++)
            run_phase(p, PHASE_ITEMS);
        drain();

        $display("Covered %0d transactions over %0d random phases plus directed edges;",
                 items_sent, phases_run);
        $display("%0d moves compared, %0d of them blocked and slid.",
                 moves_checked, moves_blocked);
        if (errors == 0 && pending == 0)
            $display("aabb_collide_and_slide_unit regression: pass");
        else
            $display("aabb_collide_and_slide_unit regression: fail");
        $finish;
    end

endmodule
